### sv/scm_pkg.sv
// Shared types, constants and the Sobel result function for the contour metrics stream.
// No dependencies; every other file of the block refers to this package by scoped names.
package scm_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Field widths
  localparam int PIX_W    = 8;
  localparam int VALUE_W  = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Result queue
  localparam int QDEPTH = 16;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;
  localparam int MAX_RUN = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_MIN = 3'd3;

  // Filter modes
  localparam logic [2:0] MODE_DX      = 3'd0;
  localparam logic [2:0] MODE_ABS_DX  = 3'd1;
  localparam logic [2:0] MODE_DY      = 3'd2;
  localparam logic [2:0] MODE_ABS_DY  = 3'd3;
  localparam logic [2:0] MODE_CONTOUR = 3'd4;
  localparam logic [2:0] MODE_MASKED  = 3'd5;

  // One result beat
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COL_W-1:0]          column;
    logic                      last;
    logic                      eof;
  } result_t;

  // Up to four results of one pixel, in emission order
  typedef struct packed {
    logic [MAX_RUN-1:0]  vld;
    result_t [MAX_RUN-1:0] item;
  } push_t;

  // Window column triple shifted down one row, bottom replicated
  function automatic logic [23:0] shift_down(input logic [23:0] t);
    return {t[23:16], t[23:16], t[15:8]};
  endfunction

  // Sobel gradients of a 3x3 window (left, center, right column triples)
  function automatic logic signed [VALUE_W-1:0] emit_value(
      input logic [23:0] lt, input logic [23:0] ct, input logic [23:0] rt,
      input logic [7:0] maskv, input logic [2:0] mode, input logic [7:0] mmin);
    logic [9:0]         col_l;
    logic [9:0]         col_r;
    logic [9:0]         row_t;
    logic [9:0]         row_b;
    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic [9:0]         ax;
    logic [9:0]         ay;
    logic [10:0]        asum;
    logic [11:0]        cm;
    logic signed [VALUE_W-1:0] v;
    col_l = {2'b0, lt[7:0]} + {1'b0, lt[15:8], 1'b0} + {2'b0, lt[23:16]};
    col_r = {2'b0, rt[7:0]} + {1'b0, rt[15:8], 1'b0} + {2'b0, rt[23:16]};
    row_t = {2'b0, lt[7:0]} + {1'b0, ct[7:0], 1'b0} + {2'b0, rt[7:0]};
    row_b = {2'b0, lt[23:16]} + {1'b0, ct[23:16], 1'b0} + {2'b0, rt[23:16]};
    dx = $signed({1'b0, col_r}) - $signed({1'b0, col_l});
    dy = $signed({1'b0, row_b}) - $signed({1'b0, row_t});
    ax = dx[10] ? 10'(-dx) : dx[9:0];
    ay = dy[10] ? 10'(-dy) : dy[9:0];
    asum = {1'b0, ax} + {1'b0, ay};
    // doubled sum, low bit set when the vertical gradient dominates
    cm = {asum, (ax < ay)};
    case (mode)
      MODE_DX:      v = {{2{dx[10]}}, dx};
      MODE_ABS_DX:  v = {3'b0, ax};
      MODE_DY:      v = {{2{dy[10]}}, dy};
      MODE_ABS_DY:  v = {3'b0, ay};
      MODE_CONTOUR: v = {1'b0, cm};
      MODE_MASKED:  v = (maskv < mmin) ? '0 : {1'b0, cm};
      default:      v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/scm_if.sv
// Valid/ready channel interfaces: pixel input, result output and register writes.
// Depends on scm_pkg for field widths.
interface scm_in_if;
  logic                        valid;
  logic                        ready;
  logic [scm_pkg::PIX_W-1:0]   pixel;
  logic [scm_pkg::PIX_W-1:0]   mask_value;
  modport source (output valid, output pixel, output mask_value, input ready);
  modport sink   (input valid, input pixel, input mask_value, output ready);
endinterface

interface scm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [scm_pkg::VALUE_W-1:0] result_value;
  logic [scm_pkg::COL_W-1:0]          result_column;
  logic                               last_in_run;
  logic                               end_of_frame;
  modport source (output valid, output result_value, output result_column,
                  output last_in_run, output end_of_frame, input ready);
  modport sink   (input valid, input result_value, input result_column,
                  input last_in_run, input end_of_frame, output ready);
endinterface

interface scm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [scm_pkg::CFG_IDX_W-1:0]   index;
  logic [scm_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/scm_result_fifo.sv
// Result queue: takes up to four results per cycle, hands out one beat per cycle while out_bus.ready is high.
// Depends on scm_pkg (result_t, push_t, depth) and scm_out_if.
module scm_result_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scm_pkg::push_t             push,
  output logic [scm_pkg::QCNT_W-1:0] count,
  scm_out_if.source                  out_bus
);

  scm_pkg::result_t             mem [scm_pkg::QDEPTH];
  logic [scm_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [scm_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [scm_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic [scm_pkg::QPTR_W-1:0]   slot_idx [scm_pkg::MAX_RUN];
  logic [2:0]                   push_n;
  logic                         pop;

  // compact the valid results onto consecutive slots
  always_comb begin
    push_n = '0;
    for (int i = 0; i < scm_pkg::MAX_RUN; i++) begin
      slot_idx[i] = wr_ptr_r + scm_pkg::QPTR_W'(push_n);
      if (push.vld[i]) begin
        push_n = push_n + 3'd1;
      end
    end
  end

  assign pop        = out_bus.valid && out_bus.ready;
  assign wr_ptr_nxt = wr_ptr_r + scm_pkg::QPTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + scm_pkg::QPTR_W'(pop);
  assign count_nxt  = count_r + scm_pkg::QCNT_W'(push_n) - scm_pkg::QCNT_W'(pop);

  // storage, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < scm_pkg::MAX_RUN; i++) begin
      if (push.vld[i]) begin
        mem[slot_idx[i]] <= push.item[i];
      end
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // head beat
  assign count                 = count_r;
  assign out_bus.valid         = (count_r != '0);
  assign out_bus.result_value  = mem[rd_ptr_r].value;
  assign out_bus.result_column = mem[rd_ptr_r].column;
  assign out_bus.last_in_run   = mem[rd_ptr_r].last;
  assign out_bus.end_of_frame  = mem[rd_ptr_r].eof;

endmodule

### sv/sobel_contour_metrics_stream.sv
// 3x3 Sobel filter with contour metrics over a raster pixel stream.
// A pixel's results pass the stage 1 registers and the result queue on the way out.
// Throughput: one pixel per cycle while each pixel yields at most one result and the
// output is not stalled; on the last row (two results per pixel) input is held back,
// paced by the single output beat per cycle draining the 16-entry result queue.
// Reset is synchronous, active low; the line stores are not cleared.
module sobel_contour_metrics_stream (
  input  logic      clk,
  input  logic      rst_n,
  scm_in_if.sink    in_bus,
  scm_out_if.source out_bus,
  scm_cfg_if.sink   cfg_bus
);

  localparam int COL_W = scm_pkg::COL_W;

  // configuration registers
  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [2:0]  mode_r;
  logic [7:0]  mmin_r;
  logic        cfg_wr;
  logic        restart;

  assign cfg_bus.ready = 1'b1;
  assign cfg_wr        = cfg_bus.valid && cfg_bus.ready;

  always_comb begin
    restart = 1'b0;
    if (cfg_wr) begin
      case (cfg_bus.index)
        scm_pkg::REG_WIDTH, scm_pkg::REG_HEIGHT,
        scm_pkg::REG_MODE, scm_pkg::REG_MASK_MIN: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'(scm_pkg::MAX_WIDTH);
      height_r <= 16'd1;
      mode_r   <= scm_pkg::MODE_DX;
      mmin_r   <= 8'd0;
    end else if (cfg_wr) begin
      case (cfg_bus.index)
        scm_pkg::REG_WIDTH:    width_r  <= cfg_bus.data[11:0];
        scm_pkg::REG_HEIGHT:   height_r <= cfg_bus.data[15:0];
        scm_pkg::REG_MODE:     mode_r   <= cfg_bus.data[2:0];
        scm_pkg::REG_MASK_MIN: mmin_r   <= cfg_bus.data[7:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [11:0] w_eff;
  logic [15:0] h_eff;
  always_comb begin
    if (width_r < 12'd2) w_eff = 12'd2;
    else if (width_r > 12'(scm_pkg::MAX_WIDTH)) w_eff = 12'(scm_pkg::MAX_WIDTH);
    else w_eff = width_r;
    h_eff = (height_r == 16'd0) ? 16'd1 : height_r;
  end

  // position counters (accept stage)
  logic [COL_W-1:0] col_r, col_nxt, col_cur;
  logic [15:0]      row_r, row_nxt, row_cur;
  logic             is_last_col, is_last_row;
  logic             accept;
  logic [scm_pkg::QCNT_W-1:0] q_count;
  logic [scm_pkg::QCNT_W:0]   q_occ;
  logic             s1_valid_r;

  assign col_cur     = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
  assign row_cur     = (row_r >= h_eff) ? '0 : row_r;
  assign is_last_col = ({1'b0, col_cur} == (w_eff - 12'd1));
  assign is_last_row = (row_cur == (h_eff - 16'd1));

  // room for a full run of the pixel in flight and of the new one
  assign q_occ = {1'b0, q_count}
               + (s1_valid_r ? (scm_pkg::QCNT_W+1)'(scm_pkg::MAX_RUN) : '0);
  assign in_bus.ready = rst_n
      && (q_occ <= (scm_pkg::QCNT_W+1)'(scm_pkg::QDEPTH - scm_pkg::MAX_RUN));
  assign accept = in_bus.valid && in_bus.ready;

  always_comb begin
    col_nxt = col_cur + 1'b1;
    row_nxt = row_cur;
    if (is_last_col) begin
      col_nxt = '0;
      row_nxt = is_last_row ? '0 : row_cur + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage 1 registers
  logic [7:0]       s1_px_r, s1_mk_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_row0_r, s1_row1_r, s1_lrow_r, s1_lcol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= in_bus.pixel;
      s1_mk_r   <= in_bus.mask_value;
      s1_col_r  <= col_cur;
      s1_row0_r <= (row_cur == 16'd0);
      s1_row1_r <= (row_cur == 16'd1);
      s1_lrow_r <= is_last_row;
      s1_lcol_r <= is_last_col;
    end
  end

  // line store, {mask, middle, upper} per column: read at accept, written back in stage 1
  logic [23:0] line_mem [scm_pkg::MAX_WIDTH];
  logic [23:0] rd_line_r;
  logic [7:0]  rd_up, rd_mid, rd_mask;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      line_mem[s1_col_r] <= {s1_mk_r, s1_px_r, rd_mid};
    end
    if (accept) begin
      rd_line_r <= line_mem[col_cur];
    end
  end

  assign rd_up   = rd_line_r[7:0];
  assign rd_mid  = rd_line_r[15:8];
  assign rd_mask = rd_line_r[23:16];

  // new window column, top in the low byte
  logic [23:0] t_col;
  always_comb begin
    if (s1_row0_r)      t_col = {s1_px_r, s1_px_r, s1_px_r};
    else if (s1_row1_r) t_col = {s1_px_r, rd_mid, rd_mid};
    else                t_col = {s1_px_r, rd_mid, rd_up};
  end

  // pixel window and mask delay
  logic [23:0] win0_r, win1_r;
  logic [7:0]  mdel0_r, mdel1_r;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      win0_r  <= '0;
      win1_r  <= '0;
      mdel0_r <= '0;
      mdel1_r <= '0;
    end else if (s1_valid_r) begin
      win0_r  <= t_col;
      win1_r  <= win0_r;
      mdel0_r <= rd_mask;
      mdel1_r <= s1_mk_r;
    end
  end

  // results of this pixel: row above, then the last row itself
  logic [23:0]      l_col;
  logic [COL_W-1:0] col_prev;
  logic             has_col, has_above;
  scm_pkg::push_t   push;

  assign l_col     = (s1_col_r == COL_W'(1)) ? win0_r : win1_r;
  assign col_prev  = s1_col_r - 1'b1;
  assign has_col   = (s1_col_r != '0);
  assign has_above = !s1_row0_r;

  always_comb begin
    push.vld[0] = s1_valid_r && has_col && has_above;
    push.vld[1] = s1_valid_r && has_col && has_above && s1_lcol_r;
    push.vld[2] = s1_valid_r && has_col && s1_lrow_r;
    push.vld[3] = s1_valid_r && has_col && s1_lrow_r && s1_lcol_r;

    push.item[0].value  = scm_pkg::emit_value(l_col, win0_r, t_col, mdel0_r,
                                              mode_r, mmin_r);
    push.item[0].column = col_prev;
    push.item[1].value  = scm_pkg::emit_value(win0_r, t_col, t_col, rd_mask,
                                              mode_r, mmin_r);
    push.item[1].column = s1_col_r;
    push.item[2].value  = scm_pkg::emit_value(scm_pkg::shift_down(l_col),
                                              scm_pkg::shift_down(win0_r),
                                              scm_pkg::shift_down(t_col),
                                              mdel1_r, mode_r, mmin_r);
    push.item[2].column = col_prev;
    push.item[3].value  = scm_pkg::emit_value(scm_pkg::shift_down(win0_r),
                                              scm_pkg::shift_down(t_col),
                                              scm_pkg::shift_down(t_col),
                                              s1_mk_r, mode_r, mmin_r);
    push.item[3].column = s1_col_r;

    // flag the final result of the run, and the frame's final result as end of frame
    for (int i = 0; i < scm_pkg::MAX_RUN; i++) begin
      push.item[i].last = 1'b0;
      push.item[i].eof  = 1'b0;
    end
    if (push.vld[3] || push.vld[2]) begin
      if (push.vld[3]) begin
        push.item[3].last = 1'b1;
        push.item[3].eof  = 1'b1;
      end else begin
        push.item[2].last = 1'b1;
      end
    end else if (push.vld[1]) begin
      push.item[1].last = 1'b1;
    end else begin
      push.item[0].last = 1'b1;
    end
  end

  scm_result_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .count   (q_count),
    .out_bus (out_bus)
  );

endmodule

### sv/scm_checker.sv
// Port-level checks on the result channel of the contour metrics stream.
// Bound to sobel_contour_metrics_stream; depends on scm_pkg for widths.
module scm_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [scm_pkg::VALUE_W-1:0] out_value,
  input logic [scm_pkg::COL_W-1:0]          out_column,
  input logic                               out_last,
  input logic                               out_eof
);

  // no result beat offered right after a reset cycle
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat offered after reset");

  // the frame's final result always closes its run
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_eof |-> out_last)
    else $error("end_of_frame without last_in_run");

  // a stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // a stalled beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_ready |=> $stable(out_value) && $stable(out_column)
                                  && $stable(out_last) && $stable(out_eof))
    else $error("result payload changed while stalled");

endmodule

bind sobel_contour_metrics_stream scm_checker u_scm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_value  (out_bus.result_value),
  .out_column (out_bus.result_column),
  .out_last   (out_bus.last_in_run),
  .out_eof    (out_bus.end_of_frame)
);
